[design/dsh_pkg.sv]
// Shared types and constants for the diamond-square heightfield generator.
// Used by the controller, the datapath and the top level.
// No dependencies.
package dsh_pkg;

    // Grid geometry. The grid is a torus of SIZE x SIZE cells.
    localparam int SIZE_LOG2  = 8;
    localparam int IDX_W      = SIZE_LOG2;
    localparam int ADDR_W     = 2 * SIZE_LOG2;
    localparam int GRID_CELLS = 1 << ADDR_W;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int H_W        = 32;
    localparam int CELL_W     = 8;
    localparam int SUM_W      = H_W + 2;
    localparam int HSUM_W     = H_W + 2;

    // Amplitude and configuration widths.
    localparam int AMP_W      = 25;
    localparam int INIT_AMP_W = 24;
    localparam int DECAY_W    = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // Offset product: signed sample times amplitude, rounded at bit 15.
    localparam int PROD_W     = SAMPLE_W + AMP_W + 1;
    localparam int OFF_SHIFT  = 15;
    localparam int OFF_W      = PROD_W - OFF_SHIFT;
    localparam logic signed [PROD_W-1:0] OFF_ROUND = PROD_W'(1 << (OFF_SHIFT - 1));

    // Amplitude decay product, rounded at bit 16 and saturated.
    localparam int APROD_W    = AMP_W + DECAY_W;
    localparam int ARND_W     = APROD_W + 1;
    localparam int AMP_SHIFT  = 16;
    localparam logic [ARND_W-1:0] AMP_ROUND = ARND_W'(1 << (AMP_SHIFT - 1));

    // Reset values.
    localparam logic [INIT_AMP_W-1:0] INIT_AMP_RST = INIT_AMP_W'(65536);
    localparam logic [DECAY_W-1:0]    DECAY_RST    = DECAY_W'(32768);
    localparam logic [AMP_W-1:0]      AMP_RST      = AMP_W'(65536);
    localparam logic [IDX_W-1:0]      RADIUS_RST   = IDX_W'(1 << (SIZE_LOG2 - 1));

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_AMP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 1'd1;

    // Pass codes. The fourth code acts as the diamond pass.
    localparam logic [1:0] PH_DIAMOND = 2'd0;
    localparam logic [1:0] PH_SQ_LEFT = 2'd1;
    localparam logic [1:0] PH_SQ_TOP  = 2'd2;

    // Neighbor read slots.
    localparam logic [1:0] NB_0 = 2'd0;
    localparam logic [1:0] NB_1 = 2'd1;
    localparam logic [1:0] NB_2 = 2'd2;
    localparam logic [1:0] NB_3 = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;     // input transfer this cycle
        logic       start_run;  // input transfer carries new_run
        logic       rd_en;      // issue one neighbor read
        logic [1:0] rd_sel;     // which neighbor to read
        logic       mul_en;     // capture the two products
        logic       off_en;     // capture the rounded offset
        logic       commit;     // write the cell, load the result, advance
    } dsh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic running;
    } dsh_status_t;

endpackage

[design/diamond_square_heightfield_top.sv]
// Top level of the diamond-square torus heightfield generator.
// Depends on dsh_pkg, dsh_ctrl and dsh_dp (which holds the dsh_ram grid).
//
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   rand_sample, new_run
//  output    out_valid / out_ready cell_row, cell_col, cell_height, run_last
//  config    cfg_we                cfg_index, cfg_data
//
// Each item that writes a cell passes through one accept state, four reads
// through the single grid memory read port, one state for the last read data
// and the rounded offset, and one write state; the result is registered when
// the cell is written, and no new item is taken before that.
// An item that arrives while no run is active and without new_run is taken
// and gives no result.
// The grid needs no clearing pass after reset or at new_run.
// A stalled output holds the write cycle; the next item is taken meanwhile
// only after that cell is written into the output register.
module diamond_square_heightfield_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dsh_pkg::SAMPLE_W-1:0]   rand_sample,
    input  logic                           new_run,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dsh_pkg::CELL_W-1:0]     cell_row,
    output logic [dsh_pkg::CELL_W-1:0]     cell_col,
    output logic [dsh_pkg::H_W-1:0]        cell_height,
    output logic                           run_last
);
    import dsh_pkg::*;

    dsh_cmd_t    cmd;
    dsh_status_t status;

    // Controller.
    dsh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .new_run   (new_run),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    dsh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rand_sample (rand_sample),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_height (cell_height),
        .run_last    (run_last)
    );

    // A written cell is always presented at the output next cycle.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("cell written without a result");

    // The final cell of a run leaves the generator not running.
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (!run_last || !status.running))
        else $error("run still active after its final cell");

    // A new run always starts reading neighbors in the next cycle.
    a_new_run_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && new_run) |=> cmd.rd_en)
        else $error("new run did not start a cell update");

    // A transfer without new_run while no run is active does not start work.
    a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !new_run && !status.running) |=> in_ready)
        else $error("ignored sample started a cell update");

endmodule

[design/dsh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dsh_ctrl.sv]
// Sequencing state machine for the heightfield generator.
// Depends on dsh_pkg for the command and status types.
module dsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                new_run,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dsh_pkg::dsh_status_t status,
    output dsh_pkg::dsh_cmd_t    cmd
);
    import dsh_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_ACC   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.start_run = new_run;
                    // A transfer while idle and without new_run yields nothing.
                    if (new_run || status.running)
                    begin
                        state_next = S_READ;
                        cnt_next   = NB_0;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cnt_reg;
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == NB_3)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.off_en = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // Wait until the output register is free or being drained.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= NB_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/dsh_dp.sv]
// Datapath for the heightfield generator: traversal position, amplitude,
// configuration registers, grid memory, neighbor sum and result registers.
// Depends on dsh_pkg and dsh_ram.
module dsh_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dsh_pkg::dsh_cmd_t              cmd,
    output dsh_pkg::dsh_status_t           status,
    input  logic                           cfg_we,
    input  logic [dsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [dsh_pkg::SAMPLE_W-1:0]   rand_sample,
    output logic [dsh_pkg::CELL_W-1:0]     cell_row,
    output logic [dsh_pkg::CELL_W-1:0]     cell_col,
    output logic [dsh_pkg::H_W-1:0]        cell_height,
    output logic                           run_last
);
    import dsh_pkg::*;

    // Configuration registers.
    logic [INIT_AMP_W-1:0] init_amp_reg;
    logic [DECAY_W-1:0]    decay_reg;

    // Traversal state.
    logic [IDX_W-1:0] radius_reg, radius_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next;
    logic [IDX_W-1:0] col_base_reg, col_base_next;
    logic [1:0]       phase_reg, phase_next;
    logic [AMP_W-1:0] amp_reg, amp_next;
    logic             running_reg, running_next;
    logic             last;

    // Per-item working registers.
    logic [SAMPLE_W-1:0]      sample_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [APROD_W-1:0]       amp_prod_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     rd_valid_reg;
    logic                     rd_zero_reg;

    // Result registers.
    logic [CELL_W-1:0] cell_row_reg;
    logic [CELL_W-1:0] cell_col_reg;
    logic [H_W-1:0]    cell_height_reg;
    logic              run_last_reg;

    // Combinational signals.
    logic [IDX_W-1:0]         row_cur, col_cur;
    logic [IDX_W-1:0]         row_m, row_p, col_m, col_p;
    logic [IDX_W-1:0]         nb_row, nb_col;
    logic [ADDR_W-1:0]        raddr, waddr;
    logic                     is_square;
    logic [H_W-1:0]           rdata, data_eff;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [HSUM_W-1:0] h_wide;
    logic [H_W-1:0]           h_sat;
    logic [ARND_W-1:0]        amp_rnd;
    logic [ARND_W-AMP_SHIFT-1:0] amp_q;
    logic [AMP_W-1:0]         amp_sat;
    logic [IDX_W:0]           two_r, col_step, row_step;
    logic                     pass_wrap;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_amp_reg <= INIT_AMP_RST;
            decay_reg    <= DECAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INIT_AMP: init_amp_reg <= cfg_data[INIT_AMP_W-1:0];
                CFG_DECAY:    decay_reg    <= cfg_data[DECAY_W-1:0];
                default:      ;
            endcase
        end
    end

    // Cell being updated, from the block base and the pass.
    assign is_square = (phase_reg == PH_SQ_LEFT) || (phase_reg == PH_SQ_TOP);

    always_comb
    begin
        case (phase_reg)
            PH_SQ_LEFT:
            begin
                row_cur = row_base_reg + radius_reg;
                col_cur = col_base_reg;
            end
            PH_SQ_TOP:
            begin
                row_cur = row_base_reg;
                col_cur = col_base_reg + radius_reg;
            end
            default:
            begin
                row_cur = row_base_reg + radius_reg;
                col_cur = col_base_reg + radius_reg;
            end
        endcase
    end

    // Wrapped neighbor coordinates; index arithmetic wraps at the grid size.
    assign row_m = row_cur - radius_reg;
    assign row_p = row_cur + radius_reg;
    assign col_m = col_cur - radius_reg;
    assign col_p = col_cur + radius_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            NB_0:
            begin
                nb_row = row_m;
                nb_col = is_square ? col_cur : col_m;
            end
            NB_1:
            begin
                nb_row = is_square ? row_p : row_m;
                nb_col = is_square ? col_cur : col_p;
            end
            NB_2:
            begin
                nb_row = is_square ? row_cur : row_p;
                nb_col = col_m;
            end
            default:
            begin
                nb_row = is_square ? row_cur : row_p;
                nb_col = col_p;
            end
        endcase
    end

    assign raddr = {nb_row, nb_col};
    assign waddr = {row_cur, col_cur};

    // Grid memory. Every neighbor read in a run hits a cell already written
    // in that run, except the origin, which is never written and reads zero.
    dsh_ram #(
        .WIDTH (H_W),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (waddr),
        .wdata (h_sat),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign data_eff = rd_zero_reg ? '0 : rdata;

    // Read-return tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    // Sample capture, products, offset rounding and neighbor sum.
    assign prod_rnd = prod_reg + OFF_ROUND;

    always_ff @(posedge clk)
    begin
        rd_zero_reg <= (raddr == '0);
        if (cmd.accept)
        begin
            sample_reg <= rand_sample;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= $signed(sample_reg) * $signed({1'b0, amp_reg});
            amp_prod_reg <= amp_reg * decay_reg;
        end
        if (cmd.off_en)
        begin
            off_reg <= prod_rnd[PROD_W-1:OFF_SHIFT];
        end
        if (cmd.accept)
        begin
            sum_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg <= sum_reg + {{(SUM_W-H_W){data_eff[H_W-1]}}, data_eff};
        end
    end

    // Height: floor of the mean plus the offset, saturated to 32 bits.
    assign h_wide = {{(HSUM_W-(SUM_W-2)){sum_reg[SUM_W-1]}}, sum_reg[SUM_W-1:2]}
                  + {{(HSUM_W-OFF_W){off_reg[OFF_W-1]}}, off_reg};

    always_comb
    begin
        if (h_wide[HSUM_W-1:H_W-1] == '0 || h_wide[HSUM_W-1:H_W-1] == '1)
        begin
            h_sat = h_wide[H_W-1:0];
        end
        else if (h_wide[HSUM_W-1])
        begin
            h_sat = {1'b1, {(H_W-1){1'b0}}};
        end
        else
        begin
            h_sat = {1'b0, {(H_W-1){1'b1}}};
        end
    end

    // Decayed amplitude, rounded and saturated.
    assign amp_rnd = {1'b0, amp_prod_reg} + AMP_ROUND;
    assign amp_q   = amp_rnd[ARND_W-1:AMP_SHIFT];
    assign amp_sat = (amp_q[ARND_W-AMP_SHIFT-1:AMP_W] != '0) ? '1 : amp_q[AMP_W-1:0];

    // Step to the next block of side 2r in row-major order.
    assign two_r    = {radius_reg, 1'b0};
    assign col_step = {1'b0, col_base_reg} + two_r;
    assign row_step = {1'b0, row_base_reg} + two_r;
    assign pass_wrap = col_step[IDX_W] && row_step[IDX_W];

    // Traversal advance after each cell.
    always_comb
    begin
        radius_next   = radius_reg;
        row_base_next = row_base_reg;
        col_base_next = col_base_reg;
        phase_next    = phase_reg;
        amp_next      = amp_reg;
        running_next  = running_reg;
        last          = 1'b0;
        if (cmd.start_run)
        begin
            radius_next   = RADIUS_RST;
            row_base_next = '0;
            col_base_next = '0;
            phase_next    = PH_DIAMOND;
            amp_next      = {1'b0, init_amp_reg};
            running_next  = 1'b1;
        end
        else if (cmd.commit)
        begin
            if (phase_reg != PH_SQ_LEFT)
            begin
                if (col_step[IDX_W])
                begin
                    col_base_next = '0;
                    row_base_next = row_step[IDX_W] ? '0 : row_step[IDX_W-1:0];
                end
                else
                begin
                    col_base_next = col_step[IDX_W-1:0];
                end
            end
            case (phase_reg)
                PH_SQ_LEFT:
                begin
                    phase_next = PH_SQ_TOP;
                end
                PH_SQ_TOP:
                begin
                    phase_next = PH_SQ_LEFT;
                    if (pass_wrap)
                    begin
                        // End of a radius: decay and halve.
                        amp_next    = amp_sat;
                        phase_next  = PH_DIAMOND;
                        radius_next = radius_reg >> 1;
                        if (radius_reg == IDX_W'(1))
                        begin
                            running_next = 1'b0;
                            last         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (pass_wrap)
                    begin
                        phase_next = PH_SQ_LEFT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RST;
            row_base_reg <= '0;
            col_base_reg <= '0;
            phase_reg    <= PH_DIAMOND;
            amp_reg      <= AMP_RST;
            running_reg  <= 1'b0;
        end
        else
        begin
            radius_reg   <= radius_next;
            row_base_reg <= row_base_next;
            col_base_reg <= col_base_next;
            phase_reg    <= phase_next;
            amp_reg      <= amp_next;
            running_reg  <= running_next;
        end
    end

    // Result registers, loaded when the cell is written.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            cell_row_reg    <= CELL_W'(row_cur);
            cell_col_reg    <= CELL_W'(col_cur);
            cell_height_reg <= h_sat;
            run_last_reg    <= last;
        end
    end

    assign status.running = running_reg;
    assign cell_row       = cell_row_reg;
    assign cell_col       = cell_col_reg;
    assign cell_height    = cell_height_reg;
    assign run_last       = run_last_reg;

endmodule
